// ===== src/catime_pkg.sv =====
// Shared types and constants for the constant-acceleration segment timer.
// Used by catime_front, catime_sqrt, catime_div and const_accel_segment_time.
package catime_pkg;

   // Square-root datapath: 64-bit radicand, 32-bit root, one root bit per stage
   localparam int RAD_W  = 64;
   localparam int ROOT_W = 32;
   localparam int SREM_W = ROOT_W + 2;

   // Sum and product of the two roots, quotient bits of the last divider
   localparam int SUM_W  = ROOT_W + 1;
   localparam int PROD_W = 2 * ROOT_W;
   localparam int TW_Q_W = 32;

   // Saturation values
   localparam logic [30:0] SAT31  = 31'h7FFF_FFFF;
   localparam logic [31:0] TW_CAP = 32'h8000_0000;

   typedef enum logic [2:0] {
      CSR_START_SPEED_SQ = 3'd0,
      CSR_SEGMENT_LENGTH = 3'd1,
      CSR_BRAKE_MODE     = 3'd2,
      CSR_SIGMA_VALUE    = 3'd3,
      CSR_ACCEL_RATE     = 3'd4,
      CSR_BRAKE_RATE     = 3'd5
   } catime_csr_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_DOMAIN  = 2'd2
   } catime_status_type;

   typedef struct packed {
      logic [30:0] start_speed_sq;
      logic [30:0] segment_length;
      logic        brake_mode;
      logic [31:0] sigma_value;
      logic [31:0] accel_rate;
      logic [31:0] brake_rate;
   } catime_cfg_type;

   // Item data carried beside the square roots
   typedef struct packed {
      logic        err;
      logic [31:0] speed_sq;
      logic [31:0] rate;
      logic [31:0] sigma;
      logic [31:0] ds;
   } catime_pre_type;

   // Item data carried beside the first divider
   typedef struct packed {
      logic              err;
      logic [31:0]       speed_sq;
      logic [31:0]       rate;
      logic [31:0]       sigma;
      logic              neg;
      logic              dsz;
      logic              szero;
      logic              r0z;
      logic              r1z;
      logic [SUM_W-1:0]  sum;
      logic [PROD_W-1:0] prod;
   } catime_info_type;

   // Item data carried beside the second divider
   typedef struct packed {
      catime_info_type info;
      logic [30:0]     travel;
      logic [30:0]     dspeed;
      logic            tw_ovf;
   } catime_mid_type;

   typedef struct packed {
      catime_status_type status;
      logic [31:0]       speed_sq;
      logic [30:0]       travel_time;
      logic              time_infinite;
      logic [30:0]       dt_dspeed;
      logic              dt_dspeed_infinite;
      logic [31:0]       dt_dstart;
      logic              dt_dstart_neg_infinite;
      logic [31:0]       rate_used;
      logic [31:0]       sigma_term;
   } catime_rsp_type;

endpackage

// ===== src/catime_front.sv =====
// Front end: rate select, the two rate products, speed squared and domain check.
// Depends on catime_pkg.
module catime_front import catime_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [31:0]          in_ds,
   input  catime_cfg_type       cfg,
   output logic                 out_valid,
   output logic [RAD_W-1:0]     rad_start,
   output logic [RAD_W-1:0]     rad_end,
   output catime_pre_type       out_info
);

   logic               valid_a_ff;
   logic signed [63:0] prod_ds_ff, prod_l_ff, w0s_ff;
   logic signed [63:0] prod_ds_in, prod_l_in, w0s_in;
   logic [31:0]        rate_a_ff, sigma_a_ff, ds_a_ff;
   logic [31:0]        rate_in, sigma_in;

   logic               valid_b_ff;
   logic signed [63:0] wf_in, wend_in, wf_sh;
   logic [RAD_W-1:0]   rad_start_ff, rad_end_ff;
   catime_pre_type     info_b_ff, info_in;

   // Stage A: select the rate and form both products
   always_comb begin
      rate_in    = cfg.brake_mode ? cfg.brake_rate : cfg.accel_rate;
      sigma_in   = cfg.brake_mode ? cfg.sigma_value : 32'd0;
      prod_ds_in = $signed(rate_in) * $signed(in_ds);
      prod_l_in  = $signed(rate_in) * $signed({1'b0, cfg.segment_length});
      w0s_in     = $signed({33'd0, cfg.start_speed_sq} << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ds_ff <= prod_ds_in;
         prod_l_ff  <= prod_l_in;
         w0s_ff     <= w0s_in;
         rate_a_ff  <= rate_in;
         sigma_a_ff <= sigma_in;
         ds_a_ff    <= in_ds;
      end
   end

   // Stage B: add the start term, flag a negative speed squared, saturate
   always_comb begin
      wf_in         = prod_ds_ff + w0s_ff;
      wend_in       = prod_l_ff + w0s_ff;
      wf_sh         = wf_in >>> FRAC_BITS;
      info_in.err   = wf_in[63] | wend_in[63];
      info_in.speed_sq = (wf_sh > $signed({33'd0, SAT31})) ? {1'b0, SAT31}
                                                           : wf_sh[31:0];
      info_in.rate  = rate_a_ff;
      info_in.sigma = sigma_a_ff;
      info_in.ds    = ds_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_start_ff <= w0s_ff;
         rad_end_ff   <= wf_in;
         info_b_ff    <= info_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign rad_start = rad_start_ff;
   assign rad_end   = rad_end_ff;
   assign out_info  = info_b_ff;

endmodule

// ===== src/catime_sqrt.sv =====
// Pipelined integer square root, two lanes, one root bit per stage.
// Depends on catime_pkg.
module catime_sqrt import catime_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  rad_start,
   input  logic [RAD_W-1:0]  rad_end,
   input  catime_pre_type    in_info,
   output logic              out_valid,
   output logic [ROOT_W-1:0] root_start,
   output logic [ROOT_W-1:0] root_end,
   output catime_pre_type    out_info
);

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sq_lane_type;

   // One restoring step: bring down two radicand bits, try 4*root+1
   function automatic sq_lane_type sqrt_step(sq_lane_type cur);
      sq_lane_type       nxt;
      logic [SREM_W+1:0] rem4;
      logic [SREM_W+1:0] trial;
      rem4    = {cur.rem, cur.rad[RAD_W-1 -: 2]};
      trial   = {2'b00, cur.root, 2'b01};
      nxt.rad = cur.rad << 2;
      if (rem4 >= trial) begin
         nxt.rem  = SREM_W'(rem4 - trial);
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = SREM_W'(rem4);
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic           valid_ff [ROOT_W];
   sq_lane_type    lane_ff  [ROOT_W][2];
   catime_pre_type info_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      sq_lane_type    src [2];
      logic           src_valid;
      catime_pre_type src_info;

      if (i == 0) begin : g_first
         assign src[0]    = '{rad: rad_start, rem: '0, root: '0};
         assign src[1]    = '{rad: rad_end, rem: '0, root: '0};
         assign src_valid = in_valid;
         assign src_info  = in_info;
      end else begin : g_next
         assign src[0]    = lane_ff[i-1][0];
         assign src[1]    = lane_ff[i-1][1];
         assign src_valid = valid_ff[i-1];
         assign src_info  = info_ff[i-1];
      end

      // Advance the valid bit with the data
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lane_ff[i][0] <= sqrt_step(src[0]);
            lane_ff[i][1] <= sqrt_step(src[1]);
            info_ff[i]    <= src_info;
         end
      end
   end

   assign out_valid  = valid_ff[ROOT_W-1];
   assign root_start = lane_ff[ROOT_W-1][0].root;
   assign root_end   = lane_ff[ROOT_W-1][1].root;
   assign out_info   = info_ff[ROOT_W-1];

endmodule

// ===== src/catime_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Computes the low Q_W quotient bits; num >> Q_W must be below den for an exact result.
module catime_div import catime_pkg::*; #(
   parameter int LANES  = 1,
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 33,
   parameter int Q_W    = 48,
   parameter int SIDE_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]     num,
   input  logic [LANES-1:0][DEN_W-1:0]     den,
   input  logic [SIDE_W-1:0]               side_in,
   output logic                            out_valid,
   output logic [LANES-1:0][Q_W-1:0]       quo,
   output logic [LANES-1:0][DEN_W-1:0]     rmd,
   output logic [SIDE_W-1:0]               side_out
);

   typedef struct packed {
      logic [Q_W-1:0]   sh;
      logic [DEN_W-1:0] rem;
      logic [DEN_W-1:0] dv;
      logic [Q_W-1:0]   q;
   } dv_lane_type;

   // Shift in one numerator bit, subtract the divisor when it fits
   function automatic dv_lane_type div_step(dv_lane_type cur);
      dv_lane_type    nxt;
      logic [DEN_W:0] rem2;
      logic           qb;
      rem2 = {cur.rem, cur.sh[Q_W-1]};
      qb   = (rem2 >= {1'b0, cur.dv});
      nxt.sh  = cur.sh << 1;
      nxt.rem = qb ? DEN_W'(rem2 - {1'b0, cur.dv}) : DEN_W'(rem2);
      nxt.dv  = cur.dv;
      nxt.q   = {cur.q[Q_W-2:0], qb};
      return nxt;
   endfunction

   logic              valid_ff [Q_W];
   dv_lane_type       lane_ff  [Q_W][LANES];
   logic [SIDE_W-1:0] side_ff  [Q_W];

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      dv_lane_type       src [LANES];
      logic              src_valid;
      logic [SIDE_W-1:0] src_side;

      for (genvar k = 0; k < LANES; k++) begin : g_lane
         if (i == 0) begin : g_first
            assign src[k] = '{sh: Q_W'(num[k]), rem: DEN_W'(num[k] >> Q_W),
                              dv: den[k], q: '0};
         end else begin : g_next
            assign src[k] = lane_ff[i-1][k];
         end

         always_ff @(posedge clock) begin
            if (en) begin
               lane_ff[i][k] <= div_step(src[k]);
            end
         end
      end

      if (i == 0) begin : g_first_ctl
         assign src_valid = in_valid;
         assign src_side  = side_in;
      end else begin : g_next_ctl
         assign src_valid = valid_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      // Advance the valid bit with the data
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i] <= src_side;
         end
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_out
      assign quo[k] = lane_ff[Q_W-1][k].q;
      assign rmd[k] = lane_ff[Q_W-1][k].rem;
   end

   assign out_valid = valid_ff[Q_W-1];
   assign side_out  = side_ff[Q_W-1];

endmodule

// ===== src/const_accel_segment_time.sv =====
// Constant-acceleration segment timer: speed squared, travel time and derivative terms.
// Pipeline depth is set by the 32-stage square root and the two bit-per-stage dividers.
// Throughput: one item per cycle while req_stall is low; a one-entry skid holds a result
// when the output stalls, and the pipeline and req_stall then hold until it drains.
// Reset clears the configuration registers to zero and empties every pipeline stage.
// Depends on catime_pkg, catime_front, catime_sqrt and catime_div.
module const_accel_segment_time import catime_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_dist_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_speed_sq,
   output logic [30:0] rsp_travel_time,
   output logic        rsp_time_infinite,
   output logic [30:0] rsp_dt_dspeed,
   output logic        rsp_dt_dspeed_infinite,
   output logic [31:0] rsp_dt_dstart,
   output logic        rsp_dt_dstart_neg_infinite,
   output logic [31:0] rsp_rate_used,
   output logic [31:0] rsp_sigma_term,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int N1_W = 32 + FRAC_BITS;
   localparam int N2_W = N1_W + FRAC_BITS;
   localparam logic [N1_W-1:0] ONE_2F = N1_W'(1) << (2 * FRAC_BITS);
   localparam int INFO_W = $bits(catime_info_type);
   localparam int MID_W  = $bits(catime_mid_type);

   logic           en;
   catime_cfg_type cfg_ff;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (catime_csr_type'(csr_index))
            CSR_START_SPEED_SQ: cfg_ff.start_speed_sq <= csr_data[30:0];
            CSR_SEGMENT_LENGTH: cfg_ff.segment_length <= csr_data[30:0];
            CSR_BRAKE_MODE:     cfg_ff.brake_mode     <= csr_data[0];
            CSR_SIGMA_VALUE:    cfg_ff.sigma_value    <= csr_data;
            CSR_ACCEL_RATE:     cfg_ff.accel_rate     <= csr_data;
            CSR_BRAKE_RATE:     cfg_ff.brake_rate     <= csr_data;
            default: ;
         endcase
      end
   end

   // Front end and square roots
   logic             fr_valid;
   logic [RAD_W-1:0] fr_rad_start, fr_rad_end;
   catime_pre_type   fr_info;

   catime_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_ds     (req_dist_req),
      .cfg       (cfg_ff),
      .out_valid (fr_valid),
      .rad_start (fr_rad_start),
      .rad_end   (fr_rad_end),
      .out_info  (fr_info)
   );

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_r0, sq_r1;
   catime_pre_type    sq_info;

   catime_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (fr_valid),
      .rad_start  (fr_rad_start),
      .rad_end    (fr_rad_end),
      .in_info    (fr_info),
      .out_valid  (sq_valid),
      .root_start (sq_r0),
      .root_end   (sq_r1),
      .out_info   (sq_info)
   );

   // Stage D: root sum and product, distance magnitude, zero flags
   logic              valid_d_ff;
   catime_info_type   info_d_ff, info_d_in;
   logic [31:0]       mag_d_ff, mag_d_in;
   logic [ROOT_W-1:0] r1_d_ff;

   always_comb begin
      info_d_in.err      = sq_info.err;
      info_d_in.speed_sq = sq_info.speed_sq;
      info_d_in.rate     = sq_info.rate;
      info_d_in.sigma    = sq_info.sigma;
      info_d_in.neg      = sq_info.ds[31];
      info_d_in.dsz      = (sq_info.ds == 32'd0);
      info_d_in.r0z      = (sq_r0 == '0);
      info_d_in.r1z      = (sq_r1 == '0);
      info_d_in.szero    = info_d_in.r0z & info_d_in.r1z;
      info_d_in.sum      = {1'b0, sq_r0} + {1'b0, sq_r1};
      info_d_in.prod     = sq_r0 * sq_r1;
      mag_d_in           = sq_info.ds[31] ? (~sq_info.ds + 32'd1) : sq_info.ds;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else if (en) begin
         valid_d_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         info_d_ff <= info_d_in;
         mag_d_ff  <= mag_d_in;
         r1_d_ff   <= sq_r1;
      end
   end

   // First divider: lane 0 gives |ds|*2^F / S, lane 1 gives 2^2F / R1
   logic [1:0][N1_W-1:0]  d1_num;
   logic [1:0][SUM_W-1:0] d1_den;
   logic                  d1_valid;
   logic [1:0][N1_W-1:0]  d1_quo;
   logic [1:0][SUM_W-1:0] d1_rmd;
   catime_info_type       d1_info;

   assign d1_num[0] = N1_W'(mag_d_ff) << FRAC_BITS;
   assign d1_num[1] = ONE_2F;
   assign d1_den[0] = info_d_ff.sum;
   assign d1_den[1] = {1'b0, r1_d_ff};

   catime_div #(
      .LANES(2), .NUM_W(N1_W), .DEN_W(SUM_W), .Q_W(N1_W), .SIDE_W(INFO_W)
   ) u_div_time (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_d_ff),
      .num       (d1_num),
      .den       (d1_den),
      .side_in   (info_d_ff),
      .out_valid (d1_valid),
      .quo       (d1_quo),
      .rmd       (d1_rmd),
      .side_out  (d1_info)
   );

   // Stage E: travel time from twice the quotient, saturation, overflow check
   logic              valid_e_ff;
   catime_mid_type    mid_e_ff, mid_e_in;
   logic [N2_W-1:0]   num2_e_ff, num2_e_in;
   logic [N1_W:0]     t_full;
   logic              t_round;

   always_comb begin
      t_round         = ({d1_rmd[0], 1'b0} >= {1'b0, d1_info.sum});
      t_full          = {d1_quo[0], 1'b0} + (N1_W+1)'(t_round);
      num2_e_in       = N2_W'(d1_quo[0]) << FRAC_BITS;
      mid_e_in.info   = d1_info;
      mid_e_in.travel = (t_full > (N1_W+1)'(SAT31)) ? SAT31 : t_full[30:0];
      mid_e_in.dspeed = (d1_quo[1] > N1_W'(SAT31)) ? SAT31 : d1_quo[1][30:0];
      mid_e_in.tw_ovf = (PROD_W'(num2_e_in >> TW_Q_W) >= d1_info.prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_e_ff <= 1'b0;
      end else if (en) begin
         valid_e_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_e_ff  <= mid_e_in;
         num2_e_ff <= num2_e_in;
      end
   end

   // Second divider: dq*2^F / (R0*R1), low 32 quotient bits
   logic [0:0][N2_W-1:0]   d2_num;
   logic [0:0][PROD_W-1:0] d2_den;
   logic                   d2_valid;
   logic [0:0][TW_Q_W-1:0] d2_quo;
   logic [0:0][PROD_W-1:0] d2_rmd;
   catime_mid_type         d2_mid;

   assign d2_num[0] = num2_e_ff;
   assign d2_den[0] = mid_e_ff.info.prod;

   catime_div #(
      .LANES(1), .NUM_W(N2_W), .DEN_W(PROD_W), .Q_W(TW_Q_W), .SIDE_W(MID_W)
   ) u_div_start (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_e_ff),
      .num       (d2_num),
      .den       (d2_den),
      .side_in   (mid_e_ff),
      .out_valid (d2_valid),
      .quo       (d2_quo),
      .rmd       (d2_rmd),
      .side_out  (d2_mid)
   );

   // Assemble the result, applying the special cases
   catime_rsp_type  rsp_new;
   catime_info_type fin;
   logic [31:0]     tw;

   always_comb begin
      fin     = d2_mid.info;
      tw      = (d2_mid.tw_ovf || (d2_quo[0] > TW_CAP)) ? TW_CAP : d2_quo[0];
      rsp_new = '0;
      if (fin.err) begin
         rsp_new.status = ST_DOMAIN;
      end else begin
         rsp_new.status             = ST_OK;
         rsp_new.speed_sq           = fin.speed_sq;
         rsp_new.rate_used          = fin.rate;
         rsp_new.sigma_term         = fin.sigma;
         rsp_new.dt_dspeed_infinite = fin.r1z;
         rsp_new.dt_dspeed          = fin.r1z ? SAT31 : d2_mid.dspeed;
         if (!fin.dsz) begin
            if (fin.szero) begin
               rsp_new.time_infinite          = 1'b1;
               rsp_new.travel_time            = SAT31;
               rsp_new.dt_dstart_neg_infinite = 1'b1;
               rsp_new.dt_dstart              = TW_CAP;
            end else begin
               rsp_new.travel_time = fin.neg ? 31'd0 : d2_mid.travel;
               if (fin.r0z || fin.r1z) begin
                  rsp_new.dt_dstart_neg_infinite = 1'b1;
                  rsp_new.dt_dstart              = TW_CAP;
               end else if (!fin.neg) begin
                  rsp_new.dt_dstart = 32'd0 - tw;
               end
            end
         end
      end
   end

   // Output register with one-entry skid; the pipeline holds while the skid is full
   logic           rsp_valid_ff, rsp_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   catime_rsp_type rsp_ff, rsp_in, skid_ff, skid_in;
   logic           rsp_take;

   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign rsp_take  = rsp_valid_ff & ~rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (d2_valid) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end else begin
            rsp_in       = rsp_new;
            rsp_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_status                 = rsp_ff.status;
   assign rsp_speed_sq               = rsp_ff.speed_sq;
   assign rsp_travel_time            = rsp_ff.travel_time;
   assign rsp_time_infinite          = rsp_ff.time_infinite;
   assign rsp_dt_dspeed              = rsp_ff.dt_dspeed;
   assign rsp_dt_dspeed_infinite     = rsp_ff.dt_dspeed_infinite;
   assign rsp_dt_dstart              = rsp_ff.dt_dstart;
   assign rsp_dt_dstart_neg_infinite = rsp_ff.dt_dstart_neg_infinite;
   assign rsp_rate_used              = rsp_ff.rate_used;
   assign rsp_sigma_term             = rsp_ff.sigma_term;

   // A held skid entry always sits behind a valid output
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry without a valid output");

   // A stalled output holds its result into the next cycle
   a_stalled_output_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");

   // Domain errors carry all-zero payload
   a_domain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == ST_DOMAIN) |->
         (rsp_ff.speed_sq == 32'd0) && (rsp_ff.travel_time == 31'd0) &&
         !rsp_ff.dt_dspeed_infinite && (rsp_ff.rate_used == 32'd0))
      else $error("domain error with nonzero payload");

   // Infinite travel time implies both derivative terms are infinite
   a_time_inf_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.time_infinite |->
         rsp_ff.dt_dspeed_infinite && rsp_ff.dt_dstart_neg_infinite)
      else $error("infinite time without infinite derivative flags");

endmodule

// ===== dv/tb.sv =====
// Testbench for const_accel_segment_time: random and directed distances over many settings.
// Each result is checked against a built-in predictor of the segment math.
// Depends on catime_pkg and the const_accel_segment_time RTL.
`timescale 1ns / 100ps

module tb;
   import catime_pkg::*;

   localparam int FRAC      = 16;
   localparam int LATENCY   = 101 + FRAC;
   localparam int CYCLE_CAP = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_dist_req = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_speed_sq;
   logic [30:0] rsp_travel_time;
   logic        rsp_time_infinite;
   logic [30:0] rsp_dt_dspeed;
   logic        rsp_dt_dspeed_infinite;
   logic [31:0] rsp_dt_dstart;
   logic        rsp_dt_dstart_neg_infinite;
   logic [31:0] rsp_rate_used;
   logic [31:0] rsp_sigma_term;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Shadow copy of the configuration registers
   logic [30:0] w0_reg = '0;
   logic [30:0] len_reg = '0;
   logic        brake_reg = 1'b0;
   logic [31:0] sigma_reg = '0;
   logic [31:0] accel_reg = '0;
   logic [31:0] brake_rate_reg = '0;

   catime_rsp_type segment_q[$];
   int  errors = 0;
   int  dists_sent = 0;
   int  results_seen = 0;
   int  settings_used = 0;
   int  cycles = 0;
   int  stall_left = 0;
   bit  idle_on = 1'b1;

   const_accel_segment_time uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Integer square root, one result bit per step
   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] x, res, b;
      x = v;
      res = '0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [30:0] sat31(input logic [127:0] v);
      return (v > 128'(SAT31)) ? SAT31 : v[30:0];
   endfunction

   // Expected result for one distance under the current settings
   function automatic catime_rsp_type segment_math(input logic [31:0] d);
      catime_rsp_type r;
      longint ds, rate, w0s, wend, wf;
      logic [63:0] r0, r1, s, mag;
      logic [127:0] dq, tw;
      logic neg;
      r = '0;
      ds = longint'(signed'(d));
      rate = brake_reg ? longint'(signed'(brake_rate_reg)) : longint'(signed'(accel_reg));
      w0s = longint'({33'b0, w0_reg}) <<< FRAC;
      wend = rate * longint'({33'b0, len_reg}) + w0s;
      wf = rate * ds + w0s;
      if (wend < 0 || wf < 0) begin
         r.status = ST_DOMAIN;
         return r;
      end
      r.status = ST_OK;
      r.speed_sq = {1'b0, sat31(128'(wf >>> FRAC))};
      r.rate_used = rate[31:0];
      r.sigma_term = brake_reg ? sigma_reg : '0;
      r0 = root64(64'(w0s));
      r1 = root64(64'(wf));
      s = r0 + r1;
      neg = ds < 0;
      mag = neg ? 64'(-ds) : 64'(ds);
      tw = '0;
      r.dt_dspeed_infinite = (r1 == 0);
      r.dt_dspeed = (r1 == 0) ? SAT31 : sat31((128'h1 << (2 * FRAC)) / r1);
      if (ds != 0) begin
         if (s == 0) begin
            r.time_infinite = 1'b1;
            r.travel_time = SAT31;
            r.dt_dspeed_infinite = 1'b1;
            r.dt_dspeed = SAT31;
            r.dt_dstart_neg_infinite = 1'b1;
            tw = 128'(TW_CAP);
         end else begin
            dq = (128'(mag) << FRAC) / s;
            r.travel_time = neg ? '0 : sat31((128'(mag) << (FRAC + 1)) / s);
            if (r0 == 0 || r1 == 0) begin
               r.dt_dstart_neg_infinite = 1'b1;
               tw = 128'(TW_CAP);
            end else if (!neg) begin
               tw = (dq << FRAC) / (128'(r0) * 128'(r1));
               if (tw > 128'(TW_CAP)) tw = 128'(TW_CAP);
            end
         end
      end
      r.dt_dstart = 32'(0) - tw[31:0];
      return r;
   endfunction

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h, expected %h (t=%0t)", field, got, want, $realtime);
   endtask

   // Predict at each input transfer
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) segment_q.push_back(segment_math(req_dist_req));
   end

   // Check each result transfer against the oldest prediction
   always @(posedge clock) begin
      catime_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (segment_q.size() == 0) begin
            report("unexpected result", 32'(rsp_status), 32'd0);
         end else begin
            e = segment_q.pop_front();
            if (rsp_status !== e.status) report("status", 32'(rsp_status), 32'(e.status));
            if (rsp_speed_sq !== e.speed_sq) report("speed_sq", rsp_speed_sq, e.speed_sq);
            if (rsp_travel_time !== e.travel_time)
               report("travel_time", 32'(rsp_travel_time), 32'(e.travel_time));
            if (rsp_time_infinite !== e.time_infinite)
               report("time_infinite", 32'(rsp_time_infinite), 32'(e.time_infinite));
            if (rsp_dt_dspeed !== e.dt_dspeed)
               report("dt_dspeed", 32'(rsp_dt_dspeed), 32'(e.dt_dspeed));
            if (rsp_dt_dspeed_infinite !== e.dt_dspeed_infinite)
               report("dt_dspeed_infinite", 32'(rsp_dt_dspeed_infinite),
                      32'(e.dt_dspeed_infinite));
            if (rsp_dt_dstart !== e.dt_dstart) report("dt_dstart", rsp_dt_dstart, e.dt_dstart);
            if (rsp_dt_dstart_neg_infinite !== e.dt_dstart_neg_infinite)
               report("dt_dstart_neg_infinite", 32'(rsp_dt_dstart_neg_infinite),
                      32'(e.dt_dstart_neg_infinite));
            if (rsp_rate_used !== e.rate_used) report("rate_used", rsp_rate_used, e.rate_used);
            if (rsp_sigma_term !== e.sigma_term)
               report("sigma_term", rsp_sigma_term, e.sigma_term);
         end
      end
   end

   // Hold off results in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_dist(input logic [31:0] d);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dist_req <= d;
      dists_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (segment_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // Write all six registers while the pipe is empty
   task automatic set_config(input logic [31:0] w0, input logic [31:0] len, input logic bm,
                             input logic [31:0] sig, input logic [31:0] ar,
                             input logic [31:0] br);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_START_SPEED_SQ; csr_data <= w0;  @(posedge clock);
      csr_index <= CSR_SEGMENT_LENGTH; csr_data <= len; @(posedge clock);
      csr_index <= CSR_BRAKE_MODE;     csr_data <= {31'b0, bm}; @(posedge clock);
      csr_index <= CSR_SIGMA_VALUE;    csr_data <= sig; @(posedge clock);
      csr_index <= CSR_ACCEL_RATE;     csr_data <= ar;  @(posedge clock);
      csr_index <= CSR_BRAKE_RATE;     csr_data <= br;  @(posedge clock);
      csr_wr_en <= 1'b0;
      w0_reg = w0[30:0];
      len_reg = len[30:0];
      brake_reg = bm;
      sigma_reg = sig;
      accel_reg = ar;
      brake_rate_reg = br;
      settings_used++;
   endtask

   // Field extremes and the zero-speed, negative-distance and domain cases
   task automatic test_directed();
      // reset values: both speeds zero
      send_dist(32'd0);
      send_dist(32'd1);
      send_dist(32'h8000_0000);
      // start at rest, accelerating: start speed zero, both speeds zero at ds = 0, domain error for negative ds
      set_config(32'd0, 32'h7FFF_FFFF, 1'b0, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000);
      send_dist(32'd0);
      send_dist(32'h0001_0000);
      send_dist(32'h7FFF_FFFF);
      send_dist(32'hFFFF_FFFF);
      // braking to exactly zero at the end
      set_config(32'h0004_0000, 32'h0004_0000, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'hFFFF_0000);
      send_dist(32'h0004_0000);
      send_dist(32'h0002_0000);
      send_dist(32'h0004_0001);
      send_dist(32'hFFFF_0000);
      // end of segment unreachable: every item is a domain error
      set_config(32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 32'd5, 32'd0, 32'h8000_0000);
      send_dist(32'd0);
      send_dist(32'd7);
      // largest start speed, largest rates
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_dist(32'h7FFF_FFFF);
      send_dist(32'h8000_0000);
      send_dist(32'd1);
      send_dist(32'd0);
      set_config(32'h7FFF_FFFF, 32'd0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_dist(32'd0);
      send_dist(32'hFFFF_FFFF);
      send_dist(32'h0000_FFFF);
   endtask

   function automatic logic [31:0] rand_rate();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($urandom_range(0, 1 << 20));
         2: return -32'($urandom_range(0, 1 << 18));
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // Random settings, mostly in-segment distances with some out-of-range noise
   task automatic test_random_phase(input int count);
      logic [31:0] len, d;
      len = $urandom >> $urandom_range(1, 31);
      set_config($urandom >> $urandom_range(0, 31), {1'($urandom_range(0, 1)), len[30:0]},
                 1'($urandom_range(0, 1)), $urandom, rand_rate(), rand_rate());
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 7))
            0: d = $urandom;
            1: d = -($urandom >> $urandom_range(0, 31));
            2: d = 32'd0;
            default: d = $urandom_range(0, len[30:0]);
         endcase
         send_dist(d);
         // pause until the pipe runs empty, then resume
         if (i == count / 2 && count > 20) drain();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      for (int p = 0; p < 7; p++) test_random_phase(85);
      idle_on = 1'b0;
      test_random_phase(85);
      drain();
      $display("%0d distances under %0d settings, %0d results compared",
               dists_sent, settings_used, results_seen);
      if (errors == 0 && segment_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/catime_pkg.sv
src/catime_front.sv
src/catime_sqrt.sv
src/catime_div.sv
src/const_accel_segment_time.sv
dv/tb.sv
